// ===== hw/rtl/gtc_pkg.sv =====
// Package for the guest time charge unit: request and register codes,
// field widths, reset values and the structs passed between modules.
// No dependencies.
package gtc_pkg;

  localparam int COUNT_W    = 32;
  localparam int RATIO_W    = 20;
  localparam int DEPTH_W    = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam int FRAC_BITS_DEFAULT = 12;
  localparam int MAX_NEST_DEFAULT  = 255;

  localparam logic [RATIO_W-1:0] CYCLES_PER_TICK_RESET = 20'd11125;
  localparam logic [RATIO_W-1:0] TICKS_PER_CYCLE_RESET = 20'd1508;
  localparam logic               FULL_BILLING_RESET    = 1'b1;

  typedef enum logic [2:0] {
    REQ_SETTLE  = 3'd0,
    REQ_PAUSE   = 3'd1,
    REQ_EXCLUDE = 3'd2,
    REQ_RESUME  = 3'd3,
    REQ_ARM     = 3'd4,
    REQ_START   = 3'd5
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLES_PER_TICK = 2'd0,
    CFG_TICKS_PER_CYCLE = 2'd1,
    CFG_FULL_BILLING    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [RATIO_W-1:0] cycles_per_tick_q12;
    logic [RATIO_W-1:0] ticks_per_cycle_q12;
    logic               full_billing;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [COUNT_W-1:0] counter_now;
    logic [COUNT_W-1:0] arm_cycles;   // two's complement bits
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cycles_taken;
    logic [COUNT_W-1:0] alarm_ticks;
    logic               alarm_started;
    logic               redundant_resume;
    logic [COUNT_W-1:0] total_ticks;
    logic [COUNT_W-1:0] total_cycles;
  } result_t;

endpackage

// ===== hw/rtl/gtc_cfg_regs.sv =====
// Configuration register file of the guest time charge unit.
// Depends on gtc_pkg for register codes, widths and reset values.
module gtc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gtc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gtc_pkg::cfg_t                   cfg
);

  // Writes are always accepted; the register file never stalls them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cycles_per_tick_q12 <= gtc_pkg::CYCLES_PER_TICK_RESET;
      cfg.ticks_per_cycle_q12 <= gtc_pkg::TICKS_PER_CYCLE_RESET;
      cfg.full_billing        <= gtc_pkg::FULL_BILLING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gtc_pkg::cfg_idx_t'(cfg_index))
        gtc_pkg::CFG_CYCLES_PER_TICK: begin
          cfg.cycles_per_tick_q12 <= cfg_data[gtc_pkg::RATIO_W-1:0];
        end
        gtc_pkg::CFG_TICKS_PER_CYCLE: begin
          cfg.ticks_per_cycle_q12 <= cfg_data[gtc_pkg::RATIO_W-1:0];
        end
        gtc_pkg::CFG_FULL_BILLING: begin
          cfg.full_billing <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/gtc_ratio_mul.sv =====
// Shared fixed-point ratio multiplier: a 32 by 20 product plus a fraction
// addend, split into whole and fractional parts. Depends on gtc_pkg.
module gtc_ratio_mul #(
  parameter int FRAC_BITS = gtc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic [gtc_pkg::COUNT_W-1:0] operand,
  input  logic [gtc_pkg::RATIO_W-1:0] ratio,
  input  logic [FRAC_BITS-1:0]        addend,
  output logic [gtc_pkg::COUNT_W-1:0] whole,
  output logic [FRAC_BITS-1:0]        frac
);

  localparam int PROD_W = gtc_pkg::COUNT_W + gtc_pkg::RATIO_W + 1;

  logic [PROD_W-1:0] prod;

  assign prod  = PROD_W'(operand) * PROD_W'(ratio) + PROD_W'(addend);
  assign whole = prod[FRAC_BITS +: gtc_pkg::COUNT_W];
  assign frac  = prod[FRAC_BITS-1:0];

endmodule

// ===== hw/rtl/gtc_core.sv =====
// Charge state and per-request datapath: elapsed-tick sampling, exclusion
// nesting, settle and arm conversion. Depends on gtc_pkg and gtc_ratio_mul.
module gtc_core #(
  parameter int FRAC_BITS = gtc_pkg::FRAC_BITS_DEFAULT,
  parameter int MAX_NEST  = gtc_pkg::MAX_NEST_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  gtc_pkg::item_t   item,
  input  gtc_pkg::cfg_t    cfg,
  output gtc_pkg::result_t result
);

  localparam logic [gtc_pkg::DEPTH_W-1:0] DEPTH_MAX = gtc_pkg::DEPTH_W'(MAX_NEST);

  logic [gtc_pkg::COUNT_W-1:0] last_mark, last_mark_next;
  logic [gtc_pkg::DEPTH_W-1:0] exclude_depth, exclude_depth_next;
  logic [gtc_pkg::COUNT_W-1:0] pending_ticks, pending_ticks_next;
  logic [FRAC_BITS-1:0]        fraction_carry, fraction_carry_next;
  logic [gtc_pkg::COUNT_W-1:0] ticks_sum, ticks_sum_next;
  logic [gtc_pkg::COUNT_W-1:0] cycles_sum, cycles_sum_next;

  logic [gtc_pkg::COUNT_W-1:0] pending_sampled;
  logic [gtc_pkg::DEPTH_W-1:0] depth_deeper;
  logic                        arm_positive;
  logic [gtc_pkg::COUNT_W-1:0] mul_operand;
  logic [gtc_pkg::RATIO_W-1:0] mul_ratio;
  logic [FRAC_BITS-1:0]        mul_addend;
  logic [gtc_pkg::COUNT_W-1:0] mul_whole;
  logic [FRAC_BITS-1:0]        mul_frac;

  // The down-counter wraps, so mark minus now is the elapsed count.
  assign pending_sampled = (exclude_depth == '0)
                         ? pending_ticks + (last_mark - item.counter_now)
                         : pending_ticks;
  assign depth_deeper = (exclude_depth < DEPTH_MAX) ? exclude_depth + 1'b1 : exclude_depth;
  assign arm_positive = !item.arm_cycles[gtc_pkg::COUNT_W-1] && (item.arm_cycles != '0);

  // One multiplier serves settle and arm; only one of them runs per request.
  always_comb begin
    if (gtc_pkg::req_t'(item.req_type) == gtc_pkg::REQ_ARM) begin
      mul_operand = item.arm_cycles;
      mul_ratio   = cfg.ticks_per_cycle_q12;
      mul_addend  = '0;
    end else begin
      mul_operand = pending_sampled;
      mul_ratio   = cfg.cycles_per_tick_q12;
      mul_addend  = fraction_carry;
    end
  end

  gtc_ratio_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .operand (mul_operand),
    .ratio   (mul_ratio),
    .addend  (mul_addend),
    .whole   (mul_whole),
    .frac    (mul_frac)
  );

  always_comb begin
    last_mark_next          = last_mark;
    exclude_depth_next      = exclude_depth;
    pending_ticks_next      = pending_ticks;
    fraction_carry_next     = fraction_carry;
    ticks_sum_next          = ticks_sum;
    cycles_sum_next         = cycles_sum;
    result.cycles_taken     = '0;
    result.alarm_ticks      = '0;
    result.alarm_started    = 1'b0;
    result.redundant_resume = 1'b0;
    unique case (gtc_pkg::req_t'(item.req_type))
      gtc_pkg::REQ_SETTLE: begin
        last_mark_next      = item.counter_now;
        pending_ticks_next  = '0;
        fraction_carry_next = mul_frac;
        ticks_sum_next      = ticks_sum + pending_sampled;
        cycles_sum_next     = cycles_sum + mul_whole;
        result.cycles_taken = mul_whole;
      end
      gtc_pkg::REQ_PAUSE: begin
        if (!cfg.full_billing) begin
          last_mark_next     = item.counter_now;
          pending_ticks_next = pending_sampled;
          exclude_depth_next = depth_deeper;
        end
      end
      gtc_pkg::REQ_EXCLUDE: begin
        if (!cfg.full_billing) begin
          exclude_depth_next = depth_deeper;
        end
      end
      gtc_pkg::REQ_RESUME: begin
        if (!cfg.full_billing) begin
          if (exclude_depth == '0) begin
            result.redundant_resume = 1'b1;
          end else begin
            exclude_depth_next = exclude_depth - 1'b1;
            // Leaving the outermost exclusion starts a fresh interval.
            if (exclude_depth == gtc_pkg::DEPTH_W'(1)) begin
              last_mark_next = item.counter_now;
            end
          end
        end
      end
      gtc_pkg::REQ_ARM: begin
        if (arm_positive) begin
          result.alarm_started = 1'b1;
          result.alarm_ticks   = (mul_whole == '0) ? gtc_pkg::COUNT_W'(1) : mul_whole;
        end
      end
      gtc_pkg::REQ_START: begin
        last_mark_next     = item.counter_now;
        exclude_depth_next = '0;
      end
      default: begin
      end
    endcase
    result.total_ticks  = ticks_sum_next;
    result.total_cycles = cycles_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mark      <= '0;
      exclude_depth  <= '0;
      pending_ticks  <= '0;
      fraction_carry <= '0;
      ticks_sum      <= '0;
      cycles_sum     <= '0;
    end else if (advance) begin
      last_mark      <= last_mark_next;
      exclude_depth  <= exclude_depth_next;
      pending_ticks  <= pending_ticks_next;
      fraction_carry <= fraction_carry_next;
      ticks_sum      <= ticks_sum_next;
      cycles_sum     <= cycles_sum_next;
    end
  end

endmodule

// ===== hw/rtl/guest_time_charge_unit.sv =====
// Guest time charge unit, top level: input register, charge core, result register.
// A request in the input register moves to the result register when that is free. One
// request is accepted every cycle while results are not stalled, the 32 by 20 multiply
// fitting between the two registers; a stalled result holds the input register first.
// Synchronous active-high reset clears the pipeline valids, all charge state and
// the configuration registers to their documented reset values.
module guest_time_charge_unit #(
  parameter int FRAC_BITS = gtc_pkg::FRAC_BITS_DEFAULT,
  parameter int MAX_NEST  = gtc_pkg::MAX_NEST_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gtc_pkg::CFG_DATA_W-1:0]      cfg_data,

  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [2:0]                          req_type,
  input  logic [gtc_pkg::COUNT_W-1:0]         counter_now,
  input  logic signed [gtc_pkg::COUNT_W-1:0]  arm_cycles,

  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [gtc_pkg::COUNT_W-1:0]         cycles_taken,
  output logic [gtc_pkg::COUNT_W-1:0]         alarm_ticks,
  output logic                                alarm_started,
  output logic                                redundant_resume,
  output logic [gtc_pkg::COUNT_W-1:0]         total_ticks,
  output logic [gtc_pkg::COUNT_W-1:0]         total_cycles
);

  gtc_pkg::cfg_t    cfg;
  gtc_pkg::item_t   item;
  gtc_pkg::result_t result;
  logic             item_valid;
  logic             advance;

  gtc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held request moves on whenever the result register is empty or is
  // being emptied this cycle. The charge state is updated at that same edge,
  // so back-to-back requests always see the state left by their predecessor.
  assign advance   = item_valid && (!res_valid || !res_stall);
  assign req_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item.req_type    <= req_type;
      item.counter_now <= counter_now;
      item.arm_cycles  <= arm_cycles;
    end
  end

  gtc_core #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_NEST  (MAX_NEST)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register: holds a finished transaction until it is taken; meanwhile the input
  // register can still accept one more request and holds it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cycles_taken     <= result.cycles_taken;
      alarm_ticks      <= result.alarm_ticks;
      alarm_started    <= result.alarm_started;
      redundant_resume <= result.redundant_resume;
      total_ticks      <= result.total_ticks;
      total_cycles     <= result.total_cycles;
    end
  end

endmodule

// ===== verif/guest_time_charge_unit_test.sv =====
// Self-checking testbench for the guest time charge unit: directed and random request
// transactions under several register settings, checked against an in-bench predictor.
// Depends on gtc_pkg and the guest_time_charge_unit RTL.
module guest_time_charge_unit_test;
  import gtc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;

  // Request codes that the package leaves undefined; the block must ignore them.
  localparam logic [2:0] REQ_UNUSED_SIX   = 3'd6;
  localparam logic [2:0] REQ_UNUSED_SEVEN = 3'd7;
  // The index field has room for one register that does not exist.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int HANG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic               req_valid   = 1'b0;
  logic               req_stall;
  logic [2:0]         req_type    = '0;
  logic [COUNT_W-1:0] counter_now = '0;
  logic [COUNT_W-1:0] arm_cycles  = '0;

  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [COUNT_W-1:0] cycles_taken;
  logic [COUNT_W-1:0] alarm_ticks;
  logic               alarm_started;
  logic               redundant_resume;
  logic [COUNT_W-1:0] total_ticks;
  logic [COUNT_W-1:0] total_cycles;

  guest_time_charge_unit uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req_type         (req_type),
    .counter_now      (counter_now),
    .arm_cycles       (arm_cycles),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .cycles_taken     (cycles_taken),
    .alarm_ticks      (alarm_ticks),
    .alarm_started    (alarm_started),
    .redundant_resume (redundant_resume),
    .total_ticks      (total_ticks),
    .total_cycles     (total_cycles)
  );

  always #4 clk = ~clk;

  // Requests waiting to be driven, and the results that accepted requests must produce.
  item_t   pending_requests[$];
  result_t expected_charges[$];

  int unsigned failures   = 0;
  int unsigned idle_pct   = 0;   // chance per cycle of starting an idle burst
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned quiet      = 0;
  bit          req_taken  = 1'b0;
  item_t       cur_req;
  result_t     want;

  // The predictor's copy of the configuration registers.
  logic [RATIO_W-1:0] cpt_q          = CYCLES_PER_TICK_RESET;
  logic [RATIO_W-1:0] tpc_q          = TICKS_PER_CYCLE_RESET;
  logic               full_billing_q = FULL_BILLING_RESET;

  // The predictor's copy of the charge state; all of it clears on reset.
  logic [COUNT_W-1:0] mark_q       = '0;
  logic [DEPTH_W-1:0] depth_q      = '0;
  logic [COUNT_W-1:0] pending_q    = '0;
  logic [FRAC-1:0]    carry_q      = '0;
  logic [COUNT_W-1:0] ticks_sum_q  = '0;
  logic [COUNT_W-1:0] cycles_sum_q = '0;

  // Ticks elapsed on the down-counter are only charged when nothing is excluding them,
  // but the mark always follows the counter.
  function automatic void take_reading(logic [COUNT_W-1:0] now);
    if (depth_q == '0) pending_q += mark_q - now;
    mark_q = now;
  endfunction

  function automatic void nest_deeper();
    if (32'(depth_q) < MAX_NEST_DEFAULT) depth_q++;
  endfunction

  // Works out the result of one accepted request and advances the predicted state.
  function automatic result_t predict_charge(item_t rq);
    result_t     r;
    logic [63:0] prod;
    r = '0;
    case (rq.req_type)
      REQ_SETTLE: begin
        take_reading(rq.counter_now);
        prod = 64'(pending_q) * 64'(cpt_q) + 64'(carry_q);
        ticks_sum_q += pending_q;
        pending_q = '0;
        r.cycles_taken = prod[FRAC +: COUNT_W];
        carry_q = prod[FRAC-1:0];
        cycles_sum_q += r.cycles_taken;
      end
      REQ_PAUSE: begin
        if (!full_billing_q) begin
          take_reading(rq.counter_now);
          nest_deeper();
        end
      end
      REQ_EXCLUDE: begin
        if (!full_billing_q) nest_deeper();
      end
      REQ_RESUME: begin
        if (!full_billing_q) begin
          if (depth_q == '0) begin
            r.redundant_resume = 1'b1;
          end else begin
            depth_q--;
            if (depth_q == '0) mark_q = rq.counter_now;
          end
        end
      end
      REQ_ARM: begin
        // Only a strictly positive budget starts the alarm.
        if (!rq.arm_cycles[COUNT_W-1] && rq.arm_cycles != '0) begin
          prod = 64'(rq.arm_cycles) * 64'(tpc_q);
          r.alarm_ticks = prod[FRAC +: COUNT_W];
          if (r.alarm_ticks == '0) r.alarm_ticks = COUNT_W'(1);
          r.alarm_started = 1'b1;
        end
      end
      REQ_START: begin
        mark_q = rq.counter_now;
        depth_q = '0;
      end
      default: begin
      end
    endcase
    r.total_ticks  = ticks_sum_q;
    r.total_cycles = cycles_sum_q;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
      failures++;
    end
  endtask

  // Request driver. A request is presented at the falling edge and held until a rising
  // edge accepts it. Idle bursts are inserted at random between transactions; whether
  // to idle never depends on the stall.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else if (req_valid && !req_taken) begin
      // Stalled: the payload stays exactly as it is.
    end else if (gap_left != 0) begin
      gap_left--;
      req_valid <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap_left = $urandom_range(0, 3);
      req_valid <= 1'b0;
    end else if (pending_requests.size() != 0) begin
      cur_req = pending_requests.pop_front();
      req_valid   <= 1'b1;
      req_type    <= cur_req.req_type;
      counter_now <= cur_req.counter_now;
      arm_cycles  <= cur_req.arm_cycles;
    end else begin
      req_valid <= 1'b0;
    end
    req_taken = 1'b0;
  end

  // Result stall, also in random bursts.
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 3);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Monitor. On every accepted request transaction the predictor runs on the values
  // that were on the ports; every accepted result transaction is compared, field by
  // field, with the oldest prediction still outstanding.
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      expected_charges.push_back(predict_charge(item_t'({req_type, counter_now, arm_cycles})));
      req_taken = 1'b1;
    end
    if (!rst && res_valid && !res_stall) begin
      if (expected_charges.size() == 0) begin
        $error("result transaction arrived with no request outstanding");
        failures++;
      end else begin
        want = expected_charges.pop_front();
        check_field("cycles_taken", want.cycles_taken, cycles_taken);
        check_field("alarm_ticks", want.alarm_ticks, alarm_ticks);
        check_field("alarm_started", 32'(want.alarm_started), 32'(alarm_started));
        check_field("redundant_resume", 32'(want.redundant_resume), 32'(redundant_resume));
        check_field("total_ticks", want.total_ticks, total_ticks);
        check_field("total_cycles", want.total_cycles, total_cycles);
      end
    end
  end

  // Watchdog: the run is hung if no channel completes a transaction for too long.
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (req_valid && !req_stall) || (res_valid && !res_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= HANG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_request(logic [2:0] kind, logic [31:0] now, logic [31:0] budget);
    item_t it;
    it.req_type    = kind;
    it.counter_now = now;
    it.arm_cycles  = budget;
    pending_requests.push_back(it);
  endtask

  // Writes one register and, once the write transaction has completed, mirrors it in
  // the predictor's configuration. Only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CYCLES_PER_TICK: cpt_q = data[RATIO_W-1:0];
      CFG_TICKS_PER_CYCLE: tpc_q = data[RATIO_W-1:0];
      CFG_FULL_BILLING:    full_billing_q = data[0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued request has gone in and every result has come out, then
  // lets the two-stage pipeline settle.
  task automatic drain();
    while (pending_requests.size() != 0 || expected_charges.size() != 0 || req_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Distance the down-counter moves between two events: mostly short, sometimes long,
  // now and then a jump that may wrap right round.
  function automatic logic [31:0] counter_step();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      7, 8:    return $urandom_range(3000, 1 << 20);
      9:       return $urandom;
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic logic [31:0] random_budget();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return $urandom_range(1, 8);
      2:       return 32'h8000_0000 | $urandom;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return $urandom;
      default: return $urandom_range(1, 1000000);
    endcase
  endfunction

  function automatic logic [RATIO_W-1:0] random_ratio();
    case ($urandom_range(0, 4))
      0:       return RATIO_W'(1);
      1:       return {RATIO_W{1'b1}};
      2:       return RATIO_W'(4096);
      default: return RATIO_W'($urandom_range(1, (1 << RATIO_W) - 1));
    endcase
  endfunction

  // Builds a stretch of random traffic. Most of it is well formed: a start, then a
  // descending counter with settles, nested exclusions and their resumes, and arms.
  // About one request in five is a fresh start or pure noise, unknown codes included.
  // A deep stretch first nests past the saturation point and then unwinds it, ending
  // with one more resume than there were nesting requests.
  task automatic add_random_traffic(int unsigned count, bit deep);
    logic [31:0] ctr;
    int unsigned made;
    int unsigned levels;
    int unsigned pick;
    ctr = $urandom;
    push_request(REQ_START, ctr, $urandom);
    made = 1;
    if (deep) begin
      levels = $urandom_range(256, 262);
      repeat (levels) begin
        ctr -= counter_step();
        push_request($urandom_range(0, 1) ? REQ_PAUSE : REQ_EXCLUDE, ctr, $urandom);
      end
      ctr -= counter_step();
      push_request(REQ_SETTLE, ctr, $urandom);
      repeat (levels + 1) begin
        ctr -= counter_step();
        push_request(REQ_RESUME, ctr, $urandom);
      end
      ctr -= counter_step();
      push_request(REQ_SETTLE, ctr, $urandom);
      made += 2 * levels + 3;
    end
    while (made < count) begin
      ctr -= counter_step();
      pick = $urandom_range(0, 99);
      if (pick < 30)
        push_request(REQ_SETTLE, ctr, $urandom);
      else if (pick < 42)
        push_request(REQ_PAUSE, ctr, $urandom);
      else if (pick < 50)
        push_request(REQ_EXCLUDE, ctr, $urandom);
      else if (pick < 65)
        push_request(REQ_RESUME, ctr, $urandom);
      else if (pick < 80)
        push_request(REQ_ARM, $urandom, random_budget());
      else if (pick < 84) begin
        ctr = $urandom;
        push_request(REQ_START, ctr, $urandom);
      end else
        push_request(3'($urandom_range(0, 7)), $urandom, $urandom);
      made++;
    end
  endtask

  initial begin
    int p;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_pct = 30;

    // Registers still at their reset values, so charge-all mode is on: pause, exclude
    // and resume must change nothing, and a resume is never flagged as redundant.
    @(posedge clk);
    push_request(REQ_START, 32'h0000_1000, 32'd0);
    push_request(REQ_PAUSE, 32'h0000_0F00, 32'd0);
    push_request(REQ_EXCLUDE, 32'h0000_0F00, 32'd0);
    push_request(REQ_RESUME, 32'h0000_0E80, 32'd0);
    push_request(REQ_SETTLE, 32'h0000_0E00, 32'd0);
    // Arm: a budget so small that the product rounds to zero still loads one tick;
    // zero and negative budgets start nothing.
    push_request(REQ_ARM, 32'd0, 32'd1);
    push_request(REQ_ARM, 32'd0, 32'd0);
    push_request(REQ_ARM, 32'd0, 32'hFFFF_FFFF);
    push_request(REQ_ARM, 32'd0, 32'h7FFF_FFFF);
    push_request(REQ_ARM, 32'd0, 32'h8000_0000);
    // Unknown codes leave the state alone and report only the running totals.
    push_request(REQ_UNUSED_SIX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(REQ_UNUSED_SEVEN, 32'd0, 32'd0);
    drain();

    // Both ratios at their maximum, with the unused upper data bits set, and charge-all
    // mode off. The spare index must be ignored.
    write_reg(CFG_CYCLES_PER_TICK, 32'hFFFF_FFFF);
    write_reg(CFG_TICKS_PER_CYCLE, 32'hFFFF_FFFF);
    write_reg(CFG_FULL_BILLING, 32'hFFFF_FFFE);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    @(posedge clk);
    push_request(REQ_START, 32'd0, 32'd0);
    // The counter wraps almost a full turn, so the cycle product overflows 32 bits.
    push_request(REQ_SETTLE, 32'd1, 32'd0);
    push_request(REQ_RESUME, 32'd2, 32'd0);
    push_request(REQ_PAUSE, 32'hFFFF_F000, 32'd0);
    push_request(REQ_EXCLUDE, 32'hFFFF_F000, 32'd0);
    // Settling while excluded moves the mark and converts what was already pending.
    push_request(REQ_SETTLE, 32'hFFFF_0000, 32'd0);
    push_request(REQ_RESUME, 32'hFFFE_0000, 32'd0);
    push_request(REQ_RESUME, 32'hFFFD_0000, 32'd0);
    push_request(REQ_SETTLE, 32'hFFFC_0000, 32'd0);
    push_request(REQ_ARM, 32'd0, 32'h7FFF_FFFF);
    // A start clears a pending exclusion without touching the carry or the totals.
    push_request(REQ_PAUSE, 32'hFFFB_0000, 32'd0);
    push_request(REQ_START, 32'h0001_0000, 32'd0);
    push_request(REQ_SETTLE, 32'h0000_0000, 32'd0);
    drain();

    // Random phases. The first two use the smallest and the largest ratios; the third
    // carries the deep nesting stretch with charge-all mode off; the fourth runs in
    // charge-all mode. Idling varies between phases, and the last phase has none.
    for (p = 0; p < 8; p++) begin
      write_reg(CFG_CYCLES_PER_TICK, ($urandom & 32'hFFF0_0000) |
                32'(p == 0 ? 20'd1 : p == 1 ? 20'hFFFFF : random_ratio()));
      write_reg(CFG_TICKS_PER_CYCLE, ($urandom & 32'hFFF0_0000) |
                32'(p == 0 ? 20'd1 : p == 1 ? 20'hFFFFF : random_ratio()));
      write_reg(CFG_FULL_BILLING, ($urandom & 32'hFFFF_FFFE) |
                32'(p == 3 || (p != 2 && $urandom_range(0, 3) == 0)));
      if (p == 4) write_reg(CFG_SPARE, $urandom);
      if (p == 7 || p % 3 == 1)
        idle_pct = 0;
      else
        idle_pct = (p % 3 == 0) ? 20 : 45;
      @(posedge clk);
      add_random_traffic(p == 2 ? 600 : 200, p == 2);
      drain();
    end

    if (failures == 0 && expected_charges.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
